// ===== hdl/b32d_pkg.sv =====
// Shared types and the alphabet lookup for the base32 stream decoder.
`default_nettype none
package b32d_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned ValW  = 5;
  localparam int unsigned BufW  = 7;
  localparam int unsigned CntW  = 3;
  localparam int unsigned PosW  = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned AccW  = BufW + ValW;

  typedef struct packed {
    logic [BufW-1:0] bit_buffer;
    logic [CntW-1:0] bit_count;
    logic [PosW-1:0] group_position;
  } dec_state_t;

  typedef struct packed {
    logic             present;
    logic [ByteW-1:0] out_byte;
    logic             end_of_message;
    logic             error;
  } dec_result_t;

  // Characters outside the alphabet decode as zero.
  function automatic logic [ValW-1:0] symbol_value(input logic [SymW-1:0] c);
    logic [SymW-1:0] d;
    d = '0;
    if (c >= 8'h32 && c <= 8'h39) begin
      d = c - 8'h32;
    end else if (c >= 8'h61 && c <= 8'h6b) begin
      d = c - 8'h61 + 8'd8;
    end else if (c == 8'h6d || c == 8'h6e) begin
      d = c - 8'h6d + 8'd19;
    end else if (c >= 8'h70 && c <= 8'h7a) begin
      d = c - 8'h70 + 8'd21;
    end
    return d[ValW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/b32d_step.sv =====
// Combinational decode of one character against the current packing state.
`default_nettype none
module b32d_step (
  input  wire logic [b32d_pkg::SymW-1:0] symbol,
  input  wire logic                      final_symbol,
  input  wire b32d_pkg::dec_state_t      state,
  output b32d_pkg::dec_state_t           state_next,
  output b32d_pkg::dec_result_t          result
);

  logic [b32d_pkg::AccW-1:0]  acc;
  logic [b32d_pkg::AccW-1:0]  acc_masked;
  logic [b32d_pkg::AccW-1:0]  acc_shifted;
  logic [3:0]                 cnt;
  logic [2:0]                 shift;
  logic [3:0]                 group_len;
  logic                       byte_ready;
  logic                       bad_len;
  logic [b32d_pkg::ByteW-1:0] byte_val;

  always_comb begin
    acc        = {state.bit_buffer, b32d_pkg::symbol_value(symbol)};
    cnt        = {1'b0, state.bit_count} + 4'd5;
    group_len  = {1'b0, state.group_position} + 4'd1;
    byte_ready = cnt >= 4'd8;
    shift      = 3'(cnt - 4'd8);
    acc_shifted = acc >> shift;
    byte_val   = byte_ready ? acc_shifted[b32d_pkg::ByteW-1:0] : '0;
    acc_masked = byte_ready ? (acc & ((12'd1 << shift) - 12'd1)) : acc;
    bad_len    = (group_len == 4'd1) || (group_len == 4'd3) || (group_len == 4'd6);

    if (final_symbol) begin
      state_next = '0;
      result.present        = 1'b1;
      result.out_byte       = bad_len ? '0 : byte_val;
      result.end_of_message = 1'b1;
      result.error          = bad_len;
    end else begin
      state_next.bit_buffer     = acc_masked[b32d_pkg::BufW-1:0];
      state_next.bit_count      = byte_ready ? shift : cnt[b32d_pkg::CntW-1:0];
      state_next.group_position = group_len[b32d_pkg::PosW-1:0];
      result.present        = byte_ready;
      result.out_byte       = byte_val;
      result.end_of_message = 1'b0;
      result.error          = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/base32_stream_decoder_unit.sv =====
// Top level of the base32 stream decoder: input register, decode step, result register.
//
// Input channel: symbol and final_symbol with symbol_valid / symbol_ready.
// One transaction carries one character; final_symbol marks the last one of a
// message, after which the packing state clears for the next message.
// Output channel: out_byte, end_of_message and error with result_valid /
// result_ready. A character gives zero or one result: a byte when eight bits
// have gathered, and always one result for the final character (error set,
// out_byte zero, when the final group holds 1, 3 or 6 characters).
// Timing: a character waits in the input register, and its result is written to the result register when it advances.
// Throughput: one character per cycle unless the output stalls; the lookup, shift and
// state update are combinational between the input register and the result register.
// Stall: while result_ready is low and a result waits, the character in the
// input register holds and symbol_ready drops once that register is full.
// Reset (rst, synchronous): both registers empty, packing state zero.
`default_nettype none
module base32_stream_decoder_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [b32d_pkg::SymW-1:0] symbol,
  input  wire logic                      final_symbol,
  input  wire logic                      symbol_valid,
  output logic                           symbol_ready,
  output logic [b32d_pkg::ByteW-1:0]     out_byte,
  output logic                           end_of_message,
  output logic                           error,
  output logic                           result_valid,
  input  wire logic                      result_ready
);

  logic [b32d_pkg::SymW-1:0] sym_q;
  logic                      fin_q;
  logic                      in_full;
  logic                      advance;
  b32d_pkg::dec_state_t      state;
  b32d_pkg::dec_state_t      state_next;
  b32d_pkg::dec_result_t     step_result;

  b32d_step u_step (
    .symbol       (sym_q),
    .final_symbol (fin_q),
    .state        (state),
    .state_next   (state_next),
    .result       (step_result)
  );

  assign advance      = in_full && (!result_valid || result_ready);
  assign symbol_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
      state        <= '0;
    end else begin
      if (symbol_valid && symbol_ready) begin
        in_full <= 1'b1;
        sym_q   <= symbol;
        fin_q   <= final_symbol;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance && step_result.present) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      if (advance) begin
        state <= state_next;
        if (step_result.present) begin
          out_byte       <= step_result.out_byte;
          end_of_message <= step_result.end_of_message;
          error          <= step_result.error;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/b32d_checker.sv =====
// Checker for the base32 stream decoder: predicts decoded bytes and compares every result.
module b32d_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [b32d_pkg::SymW-1:0] symbol,
  input  logic                      final_symbol,
  input  logic                      symbol_valid,
  input  logic                      symbol_ready,
  input  logic [b32d_pkg::ByteW-1:0] out_byte,
  input  logic                      end_of_message,
  input  logic                      error,
  input  logic                      result_valid,
  input  logic                      result_ready,
  output int                        mismatches,
  output int                        bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [b32d_pkg::ByteW-1:0] data;
    logic                       eom;
    logic                       err;
  } decoded_t;

  localparam logic [8*32-1:0] Alphabet = "23456789abcdefghijkmnpqrstuvwxyz";

  logic [6:0] carry_bits;
  logic [2:0] carry_cnt;
  logic [2:0] group_pos;
  decoded_t   owed_q[$];
  decoded_t   head;

  initial begin
    mismatches = 0;
    bytes_owed = 0;
  end

  function automatic logic [4:0] char_value(input logic [7:0] c);
    for (int i = 0; i < 32; i++) begin
      if (Alphabet[8*(31-i) +: 8] == c) return 5'(i);
    end
    return 5'd0;
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [3:0]  len;
    logic [7:0]  b;
    logic        got;
    logic        bad;
    decoded_t    d;
    len = {1'b0, group_pos} + 4'd1;
    acc = {carry_bits, char_value(c)};
    cnt = {1'b0, carry_cnt} + 4'd5;
    got = 1'b0;
    b   = 8'h00;
    if (cnt >= 4'd8) begin
      cnt = cnt - 4'd8;
      b   = 8'(acc >> cnt);
      acc = acc & ((12'd1 << cnt) - 12'd1);
      got = 1'b1;
    end
    if (fin) begin
      // bad final group lengths give an error transaction with a zero byte
      bad    = (len == 4'd1) || (len == 4'd3) || (len == 4'd6);
      d.data = bad ? 8'h00 : b;
      d.eom  = 1'b1;
      d.err  = bad;
      owed_q.push_back(d);
      carry_bits = '0;
      carry_cnt  = '0;
      group_pos  = '0;
    end else begin
      carry_bits = acc[6:0];
      carry_cnt  = cnt[2:0];
      group_pos  = len[2:0];
      if (got) begin
        d.data = b;
        d.eom  = 1'b0;
        d.err  = 1'b0;
        owed_q.push_back(d);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      carry_bits = '0;
      carry_cnt  = '0;
      group_pos  = '0;
      owed_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected transaction: byte %h eom %b err %b",
                   $time, out_byte, end_of_message, error);
          mismatches++;
        end else begin
          head = owed_q.pop_front();
          if (out_byte !== head.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, head.data, out_byte);
            mismatches++;
          end
          if (end_of_message !== head.eom) begin
            $display("%0t: end_of_message expected %b actual %b",
                     $time, head.eom, end_of_message);
            mismatches++;
          end
          if (error !== head.err) begin
            $display("%0t: error expected %b actual %b", $time, head.err, error);
            mismatches++;
          end
        end
      end
      if (symbol_valid && symbol_ready) decode_char(symbol, final_symbol);
    end
    bytes_owed <= owed_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the base32 stream decoder testbench: clock, reset, stimulus, receiver and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 400;
  localparam int IdleLimit   = 3000;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 12;
  localparam int HoldAfter   = 150;
  localparam int PauseAtMsg  = 8;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic [b32d_pkg::SymW-1:0]  symbol = '0;
  logic                       final_symbol = 1'b0;
  logic                       symbol_valid = 1'b0;
  logic                       result_ready = 1'b0;
  logic                       symbol_ready;
  logic [b32d_pkg::ByteW-1:0] out_byte;
  logic                       end_of_message;
  logic                       error;
  logic                       result_valid;

  int mismatches;
  int bytes_owed;
  int sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  base32_stream_decoder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .symbol         (symbol),
    .final_symbol   (final_symbol),
    .symbol_valid   (symbol_valid),
    .symbol_ready   (symbol_ready),
    .out_byte       (out_byte),
    .end_of_message (end_of_message),
    .error          (error),
    .result_valid   (result_valid),
    .result_ready   (result_ready)
  );

  b32d_checker decode_check (
    .clk            (clk),
    .rst            (rst),
    .symbol         (symbol),
    .final_symbol   (final_symbol),
    .symbol_valid   (symbol_valid),
    .symbol_ready   (symbol_ready),
    .out_byte       (out_byte),
    .end_of_message (end_of_message),
    .error          (error),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .mismatches     (mismatches),
    .bytes_owed     (bytes_owed)
  );

  always @(posedge clk) begin
    if (rst || (symbol_valid && symbol_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("[base32_stream_decoder_unit] ERROR");
    $finish;
  end

  // one character per transaction; this task drops valid only for a gap between bursts
  task automatic send_char(input logic [7:0] c, input logic fin);
    if (burst_left == 0) begin
      symbol_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    symbol       <= c;
    final_symbol <= fin;
    symbol_valid <= 1'b1;
    do @(posedge clk); while (!symbol_ready);
    burst_left--;
    sent++;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'($urandom_range(8'h61, 8'h7a));
    if (r < 8) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_char(pick_char(), i == len - 1);
    end
  endtask

  // receiver: changing stall patterns, plus one long hold while the sender keeps going
  initial begin
    int  mode;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        if (!held && sent >= HoldAfter) begin
          result_ready <= 1'b0;
          repeat (LongHold) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= ~result_ready;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int msgs;
    int len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // NUL alone: final group of one
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b0);
    send_char("z", 1'b1);
    send_char("2", 1'b0);
    send_char("9", 1'b0);
    send_char("a", 1'b1);
    send_char("k", 1'b0);
    send_char("m", 1'b0);
    send_char("n", 1'b0);
    send_char("p", 1'b1);
    // upper case and missing letters decode as zero
    send_char("z", 1'b0);
    send_char("Z", 1'b0);
    send_char("l", 1'b0);
    send_char("o", 1'b0);
    send_char("1", 1'b0);
    send_char("y", 1'b0);
    send_char(8'h80, 1'b1);

    msgs = 0;
    while (sent < 17 + RandomItems) begin
      if (msgs == PauseAtMsg) begin
        symbol_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
      end
      if ($urandom_range(0, 7) == 0) len = $urandom_range(10, 24);
      else len = $urandom_range(1, 9);
      send_message(len);
      msgs++;
    end
    symbol_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && bytes_owed == 0) begin
      $display("[base32_stream_decoder_unit] OK");
    end else begin
      $display("[base32_stream_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
